// ===== rtl/core/wrp_pkg.sv =====
// wrp_pkg: shared types, constants and the xorshift step for weighted_random_pick.
// No dependencies.
`default_nettype none
package wrp_pkg;
    localparam int unsigned MaxEntries = 7;
    localparam int unsigned DefEntries = 7;
    localparam int unsigned SumW       = 11;   // 7 * 255 fits in 11 bits
    localparam int unsigned RemW       = 32;
    localparam logic [55:0] WeightRst  = 56'h0406090A060708;
    localparam logic [27:0] GroupRst   = 28'h1232100;
    localparam logic [2:0]  FallRst    = 3'd3;

    typedef enum logic [1:0] {
        CFG_WEIGHT = 2'd0,
        CFG_GROUP  = 2'd1,
        CFG_FALL   = 2'd2
    } t_cfg_idx;

    // word travelling down the cell chain
    typedef struct packed {
        logic        vld;
        logic [6:0]  sel;
        logic [55:0] wts;
        logic [10:0] total;
        logic [31:0] rem;     // partial remainder, then roll
        logic [31:0] rng;     // advanced state
        logic [31:0] rng_in;
        logic [2:0]  zero_entry;
    } t_word;

    function automatic logic [31:0] xs_adv(input logic [31:0] x);
        logic [31:0] a, b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/wrp_mod_cell.sv =====
// wrp_mod_cell: one restoring-division cell, retires four quotient bits.
// Depends on wrp_pkg.
`default_nettype none
module wrp_mod_cell #(
    parameter int unsigned SHIFT = 28
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_en,
    input  wrp_pkg::t_word i_word,
    output wrp_pkg::t_word o_word
);
    wrp_pkg::t_word r_word, n_word;
    logic [42:0] d;
    logic [42:0] cmp;

    // conditional subtract of total<<k for k = SHIFT+3 .. SHIFT
    always_comb begin
        n_word = i_word;
        d = {11'd0, i_word.rem};
        for (int k = 3; k >= 0; k--) begin
            cmp = {32'd0, i_word.total} << (SHIFT + k);
            if (i_word.total != '0 && d >= cmp) begin
                d = d - cmp;
            end
        end
        n_word.rem = d[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
endmodule
`default_nettype wire

// ===== rtl/core/weighted_random_pick.sv =====
// weighted_random_pick: weighted pick among up to seven configured entries.
// The pipeline is an entry-select/sum stage, a chain of eight modulo cells
// (4 remainder bits each) and a prefix-compare output stage; throughput one
// word per cycle while the output is not stalled.
// The whole chain advances when the output register is free or taken.
// Reset (synchronous, active low) clears valid flags and reloads config.
`default_nettype none
module weighted_random_pick #(
    parameter int unsigned ENTRIES = wrp_pkg::DefEntries
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_func,
    input  wire  [6:0]  i_candidate_mask,
    input  wire  [3:0]  i_group_sel,
    input  wire  [31:0] i_rng_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_entry,
    output logic        o_found,
    output logic [31:0] o_rng_out,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [55:0] i_cfg_data
);
    localparam int unsigned Cells = 8;

    logic [55:0] r_weight;
    logic [27:0] r_group;
    logic [2:0]  r_fall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= wrp_pkg::WeightRst;
            r_group  <= wrp_pkg::GroupRst;
            r_fall   <= wrp_pkg::FallRst;
        end else if (i_cfg_we) begin
            case (wrp_pkg::t_cfg_idx'(i_cfg_idx))
                wrp_pkg::CFG_WEIGHT: r_weight <= i_cfg_data;
                wrp_pkg::CFG_GROUP:  r_group  <= i_cfg_data[27:0];
                wrp_pkg::CFG_FALL:   r_fall   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // chain advances whenever the output register can take a word
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // stage 0: select entries, sum weights, advance xorshift
    wrp_pkg::t_word n_s0, r_s0;
    always_comb begin
        logic [10:0] sum;
        sum = '0;
        n_s0 = '0;
        for (int i = 0; i < 7; i++) begin
            if (i < ENTRIES) begin
                n_s0.sel[i] = i_func ? (r_group[4*i +: 4] == i_group_sel)
                                     : i_candidate_mask[i];
            end
            if (n_s0.sel[i]) begin
                sum = sum + {3'd0, r_weight[8*i +: 8]};
            end
        end
        n_s0.vld        = i_valid;
        n_s0.wts        = r_weight;
        n_s0.total      = sum;
        n_s0.rng_in     = i_rng_in;
        n_s0.rng        = wrp_pkg::xs_adv(i_rng_in);
        n_s0.rem        = n_s0.rng;
        n_s0.zero_entry = i_func ? r_fall : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (adv) begin
            r_s0 <= n_s0;
        end
    end

    // modulo chain, most significant quotient bits first
    wrp_pkg::t_word w [Cells+1];
    assign w[0] = r_s0;
    for (genvar c = 0; c < Cells; c++) begin : g_cell
        wrp_mod_cell #(.SHIFT(4 * (Cells - 1 - c))) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_word (w[c]),
            .o_word (w[c+1])
        );
    end

    // output stage: prefix compare of roll against running sums
    wrp_pkg::t_word tail;
    assign tail = w[Cells];
    logic [2:0]  n_entry;
    logic        n_found;
    logic [31:0] n_rng;
    always_comb begin
        logic [10:0] run;
        logic        hit;
        run = '0;
        hit = 1'b0;
        n_entry = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (tail.sel[i]) begin
                run = run + {3'd0, tail.wts[8*i +: 8]};
                if (!hit && tail.rem < {21'd0, run}) begin
                    hit = 1'b1;
                    n_entry = 3'(i);
                end
            end
        end
        n_found = tail.total != '0;
        if (!n_found) begin
            n_entry = tail.zero_entry;
        end
        n_rng = n_found ? tail.rng : tail.rng_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= tail.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_entry   <= n_entry;
            o_found   <= n_found;
            o_rng_out <= n_rng;
        end
    end

    a_rem_lt_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld && tail.total != '0 |-> tail.rem < {21'd0, tail.total})
        else $error("remainder not reduced");
    a_found_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry) && $stable(o_rng_out))
        else $error("result changed under stall");
    a_notfound_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && tail.vld && tail.total == '0 |=> !o_found && o_rng_out == $past(tail.rng_in))
        else $error("state changed without a pick");
endmodule
`default_nettype wire

// ===== verif/wrp_checker.sv =====
// wrp_checker: watches both channels and the config port of weighted_random_pick,
// predicts each result word and compares it. Depends on wrp_pkg.
`default_nettype none
module wrp_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_in_stall,
    input  wire         i_func,
    input  wire  [6:0]  i_candidate_mask,
    input  wire  [3:0]  i_group_sel,
    input  wire  [31:0] i_rng_in,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [2:0]  i_entry,
    input  wire         i_found,
    input  wire  [31:0] i_rng_out,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [55:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [2:0]  entry;
        logic        found;
        logic [31:0] rng;
    } t_pick;

    logic [55:0] weights;
    logic [27:0] groups;
    logic [2:0]  fallback;
    t_pick       pending_picks[$];

    function automatic logic [31:0] xorshift_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic t_pick predict_pick(input logic func, input logic [6:0] mask,
                                           input logic [3:0] grp, input logic [31:0] rng);
        logic [6:0]  chosen;
        logic [31:0] total;
        logic [31:0] run;
        logic [31:0] nxt;
        logic [31:0] roll;
        logic        done;
        t_pick       r;
        total = 0;
        for (int i = 0; i < 7; i++) begin
            chosen[i] = func ? (groups[4*i +: 4] == grp) : mask[i];
            if (chosen[i])
                total += weights[8*i +: 8];
        end
        if (total == 0) begin
            // nothing weighted: state passes through, entry 0 or fallback
            r.entry = func ? fallback : 3'd0;
            r.found = 1'b0;
            r.rng   = rng;
        end else begin
            nxt  = xorshift_step(rng);
            roll = nxt % total;
            run  = 0;
            done = 1'b0;
            r.entry = 3'd0;
            for (int i = 0; i < 7; i++) begin
                if (chosen[i] && !done) begin
                    run += weights[8*i +: 8];
                    if (roll < run) begin
                        r.entry = i[2:0];
                        done    = 1'b1;
                    end
                end
            end
            r.found = 1'b1;
            r.rng   = nxt;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            weights  <= wrp_pkg::WeightRst;
            groups   <= wrp_pkg::GroupRst;
            fallback <= wrp_pkg::FallRst;
            o_errors <= 0;
            pending_picks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wrp_pkg::CFG_WEIGHT: weights  <= i_cfg_data;
                    wrp_pkg::CFG_GROUP:  groups   <= i_cfg_data[27:0];
                    wrp_pkg::CFG_FALL:   fallback <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                pending_picks.push_back(predict_pick(i_func, i_candidate_mask,
                                                     i_group_sel, i_rng_in));
            if (i_out_valid && !i_out_stall) begin
                if (pending_picks.size() == 0) begin
                    $display("%0t: unexpected word entry=%0d found=%0d rng=%h",
                             $time, i_entry, i_found, i_rng_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_picks.pop_front();
                    if (want.entry !== i_entry || want.found !== i_found
                        || want.rng !== i_rng_out) begin
                        $display("%0t: mismatch exp entry=%0d found=%0d rng=%h,",
                                 $time, want.entry, want.found, want.rng,
                                 " got entry=%0d found=%0d rng=%h",
                                 i_entry, i_found, i_rng_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= pending_picks.size();
    end
endmodule
`default_nettype wire

// ===== verif/tb_weighted_random_pick.sv =====
// tb_weighted_random_pick: stimulus and verdict for weighted_random_pick.
// Depends on wrp_pkg, weighted_random_pick and wrp_checker.
`default_nettype none
module tb_weighted_random_pick;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_func = 1'b0;
    logic [6:0]  i_candidate_mask = '0;
    logic [3:0]  i_group_sel = '0;
    logic [31:0] i_rng_in = '0;
    logic        i_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = wrp_pkg::CFG_WEIGHT;
    logic [55:0] i_cfg_data = '0;
    wire         o_stall;
    wire         o_valid;
    wire  [2:0]  o_entry;
    wire         o_found;
    wire  [31:0] o_rng_out;
    int          errors;
    int          pending;

    // receiver knobs: quiet = never stall, hold_long = one long hold-off
    logic        quiet_rx = 1'b0;
    logic        hold_long = 1'b0;
    // sender knob: no gaps between words
    logic        quiet_tx = 1'b0;

    always #5 i_clk = ~i_clk;

    weighted_random_pick u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_candidate_mask,
        .i_group_sel, .i_rng_in, .o_valid, .i_stall, .o_entry, .o_found,
        .o_rng_out, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    wrp_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_func,
        .i_candidate_mask, .i_group_sel, .i_rng_in, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_entry(o_entry), .i_found(o_found),
        .i_rng_out(o_rng_out), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // offer one word; valid only drops when a gap is drawn
    task automatic send_word(input logic func, input logic [6:0] mask,
                             input logic [3:0] grp, input logic [31:0] rng);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func           = func;
        i_candidate_mask = mask;
        i_group_sel      = grp;
        i_rng_in         = rng;
        i_valid          = 1'b1;
        // stall is stable between the settle point and the rising edge
        #1;
        while (o_stall) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender pause: all results home, then let the chain drain
    task automatic drain();
        i_valid = 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input wrp_pkg::t_cfg_idx idx, input logic [55:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // state field: mostly random, sometimes the all-zero / all-one corners
    function automatic logic [31:0] pick_rng();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // weight word: each byte zero at the given percentage, else sometimes full-scale
    function automatic logic [55:0] pick_weights(input int zero_pct);
        logic [55:0] w;
        for (int i = 0; i < 7; i++) begin
            if ($urandom_range(0, 99) < zero_pct)
                w[8*i +: 8] = 8'h00;
            else if ($urandom_range(0, 5) == 0)
                w[8*i +: 8] = 8'hFF;
            else
                w[8*i +: 8] = 8'($urandom);
        end
        return w;
    endfunction

    // receiver: per word draws a random stall or none, or the long hold-off
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall = 1'b1;
                repeat (60) @(negedge i_clk);
                hold_long = 1'b0;
            end else begin
                n = quiet_rx ? 0 : $urandom_range(0, 4);
                if (n > 0) begin
                    i_stall = 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_stall = 1'b0;
            #1;
            while (!o_valid && !hold_long) begin
                @(negedge i_clk);
                #1;
            end
            if (o_valid)
                @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [55:0] wts;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, reset config: groups 0,0,1,2,3,2,1 and fallback 3
        send_word(1'b0, 7'h00, 4'h0, 32'h1234_5678);   // empty mask
        send_word(1'b0, 7'h7F, 4'hF, 32'h0);           // zero state
        send_word(1'b0, 7'h7F, 4'h0, 32'hFFFF_FFFF);
        send_word(1'b0, 7'h40, 4'h0, 32'hDEAD_BEEF);   // last entry only
        send_word(1'b0, 7'h01, 4'h0, 32'h0000_0001);
        for (int g = 0; g < 5; g++)
            send_word(1'b1, 7'h00, g[3:0], $urandom);
        send_word(1'b1, 7'h7F, 4'hF, 32'hCAFE_0001);   // no group match
        drain();

        // zero-weight entries, fallback of seven
        write_reg(wrp_pkg::CFG_WEIGHT, 56'h00_FF_00_01_00_FF_00);
        write_reg(wrp_pkg::CFG_GROUP, 56'h0FFF_FFFF);
        write_reg(wrp_pkg::CFG_FALL, 56'd7);
        send_word(1'b0, 7'h55, 4'h0, 32'h0);           // only zero weights
        send_word(1'b0, 7'h2A, 4'h0, 32'h0);
        send_word(1'b0, 7'h7F, 4'h0, 32'hFFFF_FFFF);
        send_word(1'b1, 7'h00, 4'hF, 32'h8000_0000);
        send_word(1'b1, 7'h7F, 4'h0, 32'h7FFF_FFFF);   // fallback seven
        drain();

        // everything zero, fallback 0; then everything full
        write_reg(wrp_pkg::CFG_WEIGHT, 56'h0);
        write_reg(wrp_pkg::CFG_FALL, 56'd0);
        send_word(1'b0, 7'h7F, 4'h0, 32'hA5A5_A5A5);
        send_word(1'b1, 7'h00, 4'hF, 32'h5A5A_5A5A);
        drain();
        write_reg(wrp_pkg::CFG_WEIGHT, 56'hFF_FFFF_FFFF_FFFF);
        write_reg(wrp_pkg::CFG_GROUP, 56'h0);
        send_word(1'b1, 7'h00, 4'h0, 32'hFFFF_FFFF);
        send_word(1'b0, 7'h7F, 4'h0, 32'h0000_0010);
        send_word(1'b0, 7'h7F, 4'h0, 32'hFFFF_FFFE);
        drain();

        // random phases, each under a fresh config
        for (int ph = 0; ph < 6; ph++) begin
            wts = pick_weights(ph * 12);
            write_reg(wrp_pkg::CFG_WEIGHT, wts);
            // small group numbers except in the last phase, so that matches are common
            write_reg(wrp_pkg::CFG_GROUP, (ph == 5) ? 56'($urandom & 32'h0FFF_FFFF)
                                                    : 56'($urandom & 32'h0333_3333));
            write_reg(wrp_pkg::CFG_FALL, 56'($urandom_range(0, 7)));
            quiet_tx = (ph == 2);
            quiet_rx = (ph == 2) || (ph == 4);
            for (int k = 0; k < 190; k++) begin
                if (ph == 3 && k == 40)
                    hold_long = 1'b1;
                send_word(1'($urandom), 7'($urandom),
                          ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                      : 4'($urandom_range(0, 3)),
                          pick_rng());
            end
            drain();
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;

        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
